// ----- rtl/core/flick_scroll_controller_defines.svh -----
// ----------------------------------------------------------------------------
// flick scroll controller assertion macros
// concurrent assertion helpers used by the checker file fsc_checker
// ----------------------------------------------------------------------------
`ifndef FLICK_SCROLL_CONTROLLER_DEFINES_SVH
`define FLICK_SCROLL_CONTROLLER_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define FSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, checked through reset as well
`define FSC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types, codes and constants of the flick scroll controller
// ----------------------------------------------------------------------------
package fsc_pkg;

  // port widths
  localparam int InDataW   = 96;
  localparam int InUserW   = 2;
  localparam int OutDataW  = 96;
  localparam int OutUserW  = 3;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 12;

  // request codes
  typedef enum logic [1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_MOVE    = 2'd2,
    REQ_TICK    = 2'd3
  } req_t;

  // mode codes as shown on mode_now
  localparam logic [2:0] MODE_STEADY  = 3'd0;
  localparam logic [2:0] MODE_PRESSED = 3'd1;
  localparam logic [2:0] MODE_MANUAL  = 3'd2;
  localparam logic [2:0] MODE_AUTO    = 3'd3;
  localparam logic [2:0] MODE_STOP    = 3'd4;

  // register indexes
  localparam logic [CfgAddrW-1:0] CFG_MOVE_THRESHOLD = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_DECEL_STEP     = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_MAX_SPEED      = 2'd2;

  // register reset values
  localparam logic [7:0]  MOVE_THRESHOLD_RST = 8'd10;
  localparam logic [7:0]  DECEL_STEP_RST     = 8'd1;
  localparam logic [11:0] MAX_SPEED_RST      = 12'd64;

  // out_tuser bit positions
  localparam int UserScrollValid = 0;
  localparam int UserCustomValid = 1;
  localparam int UserReplayClick = 2;

  typedef struct packed {
    req_t               req_type;
    logic               left_only;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic [14:0]        scroll_x;
    logic [14:0]        scroll_y;
  } fsc_item_t;

  typedef struct packed {
    logic               consumed;
    logic               scroll_valid;
    logic signed [17:0] target_x;
    logic signed [17:0] target_y;
    logic               custom_valid;
    logic signed [16:0] custom_delta;
    logic               replay_click;
    logic signed [15:0] replay_x;
    logic signed [15:0] replay_y;
    logic               timer_run;
    logic [2:0]         mode_now;
  } fsc_result_t;

endpackage

// ----- rtl/core/fsc_in_reg.sv -----
// ----------------------------------------------------------------------------
// fsc_in_reg
// input register stage holding one accepted item
// ----------------------------------------------------------------------------
module fsc_in_reg
  import fsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  fsc_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output fsc_item_t dn_item
);

  logic      valid_r;
  logic      valid_nxt;
  fsc_item_t item_r;

  // stage frees up whenever its content moves on
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ----- rtl/core/fsc_core.sv -----
// ----------------------------------------------------------------------------
// fsc_core
// mode machine, drag and speed state, configuration registers
// ----------------------------------------------------------------------------
module fsc_core
  import fsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                step_en,
  input  fsc_item_t           item,
  output fsc_result_t         result
);

  typedef enum logic [2:0] {
    ST_STEADY  = MODE_STEADY,
    ST_PRESSED = MODE_PRESSED,
    ST_MANUAL  = MODE_MANUAL,
    ST_AUTO    = MODE_AUTO,
    ST_STOP    = MODE_STOP
  } mode_t;

  // clamp to +/- lim, then step toward zero by a
  function automatic logic signed [16:0] decay(input logic signed [16:0] s,
                                               input logic [7:0]  a,
                                               input logic [11:0] lim);
    logic signed [17:0] sw;
    logic signed [17:0] lw;
    logic signed [17:0] aw;
    logic signed [17:0] c;
    sw = {s[16], s};
    lw = {6'b0, lim};
    aw = {10'b0, a};
    if (sw > lw) begin
      c = lw;
    end else if (sw < -lw) begin
      c = -lw;
    end else begin
      c = sw;
    end
    if (c > 18'sd0) begin
      c = (c <= aw) ? 18'sd0 : c - aw;
    end else if (c < 18'sd0) begin
      c = (-c <= aw) ? 18'sd0 : c + aw;
    end
    return c[16:0];
  endfunction

  logic [7:0]  move_threshold_r;
  logic [7:0]  decel_step_r;
  logic [11:0] max_speed_r;

  mode_t              mode_r, mode_nxt;
  logic signed [15:0] press_x_r, press_x_nxt;
  logic signed [15:0] press_y_r, press_y_nxt;
  logic [14:0]        base_x_r, base_x_nxt;
  logic [14:0]        base_y_r, base_y_nxt;
  logic signed [15:0] last_y_r, last_y_nxt;
  logic signed [15:0] drag_x_r, drag_x_nxt;
  logic signed [15:0] drag_y_r, drag_y_nxt;
  logic signed [16:0] speed_x_r, speed_x_nxt;
  logic signed [16:0] speed_y_r, speed_y_nxt;

  logic signed [16:0] dx, dy, dly, smx, smy, dec_x, dec_y;
  logic [16:0]        adx, ady;
  logic               is_click;
  logic signed [17:0] tx_man, ty_man, tx_auto, ty_auto;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_threshold_r <= MOVE_THRESHOLD_RST;
      decel_step_r     <= DECEL_STEP_RST;
      max_speed_r      <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MOVE_THRESHOLD: move_threshold_r <= cfg_wdata[7:0];
        CFG_DECEL_STEP:     decel_step_r     <= cfg_wdata[7:0];
        CFG_MAX_SPEED:      max_speed_r      <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // travel and speed terms, all in range without wrap
  assign dx  = {item.pos_x[15], item.pos_x} - {press_x_r[15], press_x_r};
  assign dy  = {item.pos_y[15], item.pos_y} - {press_y_r[15], press_y_r};
  assign dly = {item.pos_y[15], item.pos_y} - {last_y_r[15], last_y_r};
  assign smx = {item.cursor_x[15], item.cursor_x} - {drag_x_r[15], drag_x_r};
  assign smy = {item.cursor_y[15], item.cursor_y} - {drag_y_r[15], drag_y_r};
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign is_click = (adx < {9'b0, move_threshold_r}) && (ady < {9'b0, move_threshold_r});

  assign dec_x = decay(speed_x_r, decel_step_r, max_speed_r);
  assign dec_y = decay(speed_y_r, decel_step_r, max_speed_r);

  assign tx_man  = $signed({3'b0, base_x_r}) - {dx[16], dx};
  assign ty_man  = $signed({3'b0, base_y_r}) - {dy[16], dy};
  assign tx_auto = $signed({3'b0, item.scroll_x}) - {dec_x[16], dec_x};
  assign ty_auto = $signed({3'b0, item.scroll_y}) - {dec_y[16], dec_y};

  always_comb begin
    mode_nxt    = mode_r;
    press_x_nxt = press_x_r;
    press_y_nxt = press_y_r;
    base_x_nxt  = base_x_r;
    base_y_nxt  = base_y_r;
    last_y_nxt  = last_y_r;
    drag_x_nxt  = drag_x_r;
    drag_y_nxt  = drag_y_r;
    speed_x_nxt = speed_x_r;
    speed_y_nxt = speed_y_r;
    result      = '0;

    if (item.req_type == REQ_TICK) begin
      if (mode_r == ST_MANUAL) begin
        speed_x_nxt = smx;
        speed_y_nxt = smy;
        drag_x_nxt  = item.cursor_x;
        drag_y_nxt  = item.cursor_y;
      end else if (mode_r == ST_AUTO) begin
        speed_x_nxt         = dec_x;
        speed_y_nxt         = dec_y;
        result.scroll_valid = 1'b1;
        result.target_x     = tx_auto;
        result.target_y     = ty_auto;
        result.custom_valid = 1'b1;
        result.custom_delta = dec_y;
        if (dec_x == 17'sd0 && dec_y == 17'sd0) begin
          mode_nxt = ST_STEADY;
        end
      end
    end else begin
      case (mode_r)
        ST_STEADY: begin
          if (item.req_type == REQ_PRESS && item.left_only) begin
            result.consumed = 1'b1;
            mode_nxt    = ST_PRESSED;
            press_x_nxt = item.pos_x;
            press_y_nxt = item.pos_y;
            base_x_nxt  = item.scroll_x;
            base_y_nxt  = item.scroll_y;
            last_y_nxt  = item.pos_y;
          end
        end
        ST_PRESSED: begin
          if (item.req_type == REQ_RELEASE) begin
            result.consumed     = 1'b1;
            mode_nxt            = ST_STEADY;
            result.replay_click = 1'b1;
            result.replay_x     = press_x_r;
            result.replay_y     = press_y_r;
          end else if (item.req_type == REQ_MOVE) begin
            result.consumed = 1'b1;
            mode_nxt   = ST_MANUAL;
            drag_x_nxt = item.cursor_x;
            drag_y_nxt = item.cursor_y;
          end
        end
        ST_MANUAL: begin
          if (item.req_type == REQ_MOVE) begin
            result.consumed     = 1'b1;
            result.scroll_valid = 1'b1;
            result.target_x     = tx_man;
            result.target_y     = ty_man;
            result.custom_valid = 1'b1;
            result.custom_delta = dly;
            last_y_nxt          = item.pos_y;
          end else if (item.req_type == REQ_RELEASE) begin
            result.consumed = 1'b1;
            if (is_click) begin
              mode_nxt            = ST_STEADY;
              result.replay_click = 1'b1;
              result.replay_x     = press_x_r;
              result.replay_y     = press_y_r;
            end else begin
              mode_nxt = ST_AUTO;
            end
          end
        end
        ST_AUTO: begin
          if (item.req_type == REQ_PRESS) begin
            result.consumed = 1'b1;
            mode_nxt    = ST_STOP;
            speed_x_nxt = '0;
            speed_y_nxt = '0;
            last_y_nxt  = '0;
            press_x_nxt = item.pos_x;
            press_y_nxt = item.pos_y;
            base_x_nxt  = item.scroll_x;
            base_y_nxt  = item.scroll_y;
          end else if (item.req_type == REQ_RELEASE) begin
            result.consumed = 1'b1;
            mode_nxt    = ST_STEADY;
            speed_x_nxt = '0;
            speed_y_nxt = '0;
          end
        end
        ST_STOP: begin
          if (item.req_type == REQ_RELEASE) begin
            result.consumed = 1'b1;
            mode_nxt = ST_STEADY;
          end else if (item.req_type == REQ_MOVE) begin
            result.consumed = 1'b1;
            mode_nxt   = ST_MANUAL;
            drag_x_nxt = item.cursor_x;
            drag_y_nxt = item.cursor_y;
          end
        end
        default: ;
      endcase
    end

    result.timer_run = (mode_nxt == ST_MANUAL) || (mode_nxt == ST_AUTO);
    result.mode_now  = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ST_STEADY;
      press_x_r <= '0;
      press_y_r <= '0;
      base_x_r  <= '0;
      base_y_r  <= '0;
      last_y_r  <= '0;
      drag_x_r  <= '0;
      drag_y_r  <= '0;
      speed_x_r <= '0;
      speed_y_r <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      press_x_r <= press_x_nxt;
      press_y_r <= press_y_nxt;
      base_x_r  <= base_x_nxt;
      base_y_r  <= base_y_nxt;
      last_y_r  <= last_y_nxt;
      drag_x_r  <= drag_x_nxt;
      drag_y_r  <= drag_y_nxt;
      speed_x_r <= speed_x_nxt;
      speed_y_r <= speed_y_nxt;
    end
  end

endmodule

// ----- rtl/core/fsc_out_reg.sv -----
// ----------------------------------------------------------------------------
// fsc_out_reg
// result register driving the output channel
// ----------------------------------------------------------------------------
module fsc_out_reg
  import fsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  fsc_result_t up_result,
  output logic        dn_valid,
  input  logic        dn_ready,
  output fsc_result_t dn_result
);

  logic        valid_r;
  logic        valid_nxt;
  fsc_result_t result_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result_r <= up_result;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_result = result_r;

endmodule

// ----- rtl/core/flick_scroll_controller.sv -----
// ----------------------------------------------------------------------------
// flick_scroll_controller
// kinetic flick-scroll controller for one view
// ----------------------------------------------------------------------------
// takes press, release, move and tick transfers and returns exactly one result
// transfer for each of them, in order. one item is taken every clock cycle
// while the result side keeps up; an accepted item is held in the input
// register and then moves into the result register, which offers it on the
// output, with the whole mode/drag/speed update done in the single logic stage
// between them. the input register can take the next item while a finished
// result still waits to be taken. configuration writes take effect on the next
// cycle and are meant to happen only while no transfer is in flight.
// ----------------------------------------------------------------------------
module flick_scroll_controller
  import fsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,

  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  // left_only, pos_x, pos_y, cursor_x, cursor_y, scroll_x, scroll_y, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  // req_type
  input  logic [InUserW-1:0]  in_tuser,

  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  // consumed, target_x, target_y, custom_delta, replay_x, replay_y,
  // timer_run, mode_now, zero pad
  output logic [OutDataW-1:0] out_tdata,
  // scroll_valid, custom_valid, replay_click
  output logic [OutUserW-1:0] out_tuser
);

  fsc_item_t   in_item;
  fsc_item_t   s1_item;
  logic        s1_valid;
  logic        s1_ready;
  fsc_result_t step_result;
  fsc_result_t out_result;

  // unpack the input transfer
  assign in_item.req_type  = req_t'(in_tuser[1:0]);
  assign in_item.left_only = in_tdata[0];
  assign in_item.pos_x     = in_tdata[16:1];
  assign in_item.pos_y     = in_tdata[32:17];
  assign in_item.cursor_x  = in_tdata[48:33];
  assign in_item.cursor_y  = in_tdata[64:49];
  assign in_item.scroll_x  = in_tdata[79:65];
  assign in_item.scroll_y  = in_tdata[94:80];

  // input register
  fsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_item  (s1_item)
  );

  // state update happens exactly when the item moves into the result register
  fsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step_en   (s1_valid && s1_ready),
    .item      (s1_item),
    .result    (step_result)
  );

  // result register
  fsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_result (step_result),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_result (out_result)
  );

  // pack the result transfer, lowest field first
  assign out_tdata = {6'b0,
                      out_result.mode_now,
                      out_result.timer_run,
                      out_result.replay_y,
                      out_result.replay_x,
                      out_result.custom_delta,
                      out_result.target_y,
                      out_result.target_x,
                      out_result.consumed};

  assign out_tuser[UserScrollValid] = out_result.scroll_valid;
  assign out_tuser[UserCustomValid] = out_result.custom_valid;
  assign out_tuser[UserReplayClick] = out_result.replay_click;

endmodule

// ----- rtl/core/fsc_checker.sv -----
// ----------------------------------------------------------------------------
// fsc_checker
// port-level checks of the flick scroll controller result channel
// ----------------------------------------------------------------------------
`include "flick_scroll_controller_defines.svh"

module fsc_checker
  import fsc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic [OutUserW-1:0] out_tuser
);

  logic [2:0] mode_now;
  logic       timer_run;
  logic       consumed;

  assign mode_now  = out_tdata[89:87];
  assign timer_run = out_tdata[86];
  assign consumed  = out_tdata[0];

  // a stalled result holds
  `FSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // ticks run exactly in manual and auto mode
  `FSC_ASSERT_IMPLY(a_timer_mode, out_tvalid, timer_run == ((mode_now == MODE_MANUAL) || (mode_now == MODE_AUTO)), "timer_run disagrees with mode")

  // a click replay ends the gesture and swallows the release
  `FSC_ASSERT_IMPLY(a_replay_steady, out_tvalid && out_tuser[UserReplayClick], consumed && (mode_now == MODE_STEADY), "click replay outside a consumed release")

  // no target without the flag
  `FSC_ASSERT_IMPLY(a_target_zero, out_tvalid && !out_tuser[UserScrollValid], out_tdata[36:1] == 36'd0, "scroll target given without scroll_valid")

  // the result side is empty in the first cycle out of reset
  `FSC_ASSERT_ALWAYS(a_reset_empty, rst_n && $past(!rst_n), !out_tvalid, "result valid after reset")

endmodule

bind flick_scroll_controller fsc_checker u_fsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
